>>> design/mvcr_pkg.sv
// Shared types and constants for the majority-vote code receiver.
// No dependencies; every other design file imports this package.

package mvcr_pkg;

   // Field widths.
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned RUN_W   = 3;
   localparam int unsigned EVENT_W = 3;
   localparam int unsigned INDEX_W = 3;

   // Longest allowed run of equal bits, and the saturation point of a run counter.
   localparam logic [RUN_W-1:0] MAX_RUN = 3'd5;
   localparam logic [RUN_W-1:0] RUN_SAT = 3'd7;

   // Fixed alternate codes that also toggle the outputs.
   localparam logic [WORD_W-1:0] ALT_A = 16'd23188;
   localparam logic [WORD_W-1:0] ALT_B = 16'd23187;

   // Stage event codes reported with each result item.
   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_FIRST  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_SECOND = 3'd2;
   localparam logic [EVENT_W-1:0] EV_DONE   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_ABORT  = 3'd4;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_WINDOW_TICKS = 3'd0;
   localparam logic [INDEX_W-1:0] REG_MIN_VOTES    = 3'd1;
   localparam logic [INDEX_W-1:0] REG_FIRST_SPLIT  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_SECOND_SPLIT = 3'd3;
   localparam logic [INDEX_W-1:0] REG_FRAME_END    = 3'd4;
   localparam logic [INDEX_W-1:0] REG_CODE_A       = 3'd5;
   localparam logic [INDEX_W-1:0] REG_CODE_B       = 3'd6;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] RST_WINDOW_TICKS = 8'd10;
   localparam logic [BYTE_W-1:0] RST_MIN_VOTES    = 8'd2;
   localparam logic [BYTE_W-1:0] RST_FIRST_SPLIT  = 8'd4;
   localparam logic [BYTE_W-1:0] RST_SECOND_SPLIT = 8'd5;
   localparam logic [BYTE_W-1:0] RST_FRAME_END    = 8'd24;
   localparam logic [WORD_W-1:0] RST_CODE_A       = 16'd46441;
   localparam logic [WORD_W-1:0] RST_CODE_B       = 16'd46438;

   // Configuration register set as seen by the receiver core.
   typedef struct packed {
      logic [BYTE_W-1:0] window_ticks;
      logic [BYTE_W-1:0] min_votes;
      logic [BYTE_W-1:0] first_split;
      logic [BYTE_W-1:0] second_split;
      logic [BYTE_W-1:0] frame_end;
      logic [WORD_W-1:0] code_a;
      logic [WORD_W-1:0] code_b;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic               armed_now;
      logic               bit_valid;
      logic               bit_value;
      logic [EVENT_W-1:0] stage_event;
      logic [WORD_W-1:0]  seg_first;
      logic [WORD_W-1:0]  seg_second;
      logic [WORD_W-1:0]  seg_final;
      logic               hit_a;
      logic               hit_b;
      logic               out_a;
      logic               out_b;
   } result_type;

endpackage

>>> design/mvcr_csr.sv
// Configuration register file of the majority-vote code receiver.
// Depends on mvcr_pkg for the register indexes, reset values and cfg_type.

module mvcr_csr import mvcr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [INDEX_W-1:0]  wr_index,
   input  logic [WORD_W-1:0]   wr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; unused indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_WINDOW_TICKS: cfg_in.window_ticks = wr_data[BYTE_W-1:0];
            REG_MIN_VOTES:    cfg_in.min_votes    = wr_data[BYTE_W-1:0];
            REG_FIRST_SPLIT:  cfg_in.first_split  = wr_data[BYTE_W-1:0];
            REG_SECOND_SPLIT: cfg_in.second_split = wr_data[BYTE_W-1:0];
            REG_FRAME_END:    cfg_in.frame_end    = wr_data[BYTE_W-1:0];
            REG_CODE_A:       cfg_in.code_a       = wr_data;
            REG_CODE_B:       cfg_in.code_b       = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage with documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks <= RST_WINDOW_TICKS;
         cfg_ff.min_votes    <= RST_MIN_VOTES;
         cfg_ff.first_split  <= RST_FIRST_SPLIT;
         cfg_ff.second_split <= RST_SECOND_SPLIT;
         cfg_ff.frame_end    <= RST_FRAME_END;
         cfg_ff.code_a       <= RST_CODE_A;
         cfg_ff.code_b       <= RST_CODE_B;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/mvcr_core.sv
// Receiver core: vote counters, bit decision, segment capture and code match.
// Depends on mvcr_pkg; state advances by one sample tick when fire is high.

module mvcr_core import mvcr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  logic       line_level,
   output result_type res
);

   logic              armed_ff, armed_in;
   logic [BYTE_W-1:0] tick_count_ff, tick_count_in;
   logic [WORD_W-1:0] low_votes_ff, low_votes_in;
   logic [WORD_W-1:0] high_votes_ff, high_votes_in;
   logic [RUN_W-1:0]  zero_run_ff, zero_run_in;
   logic [RUN_W-1:0]  one_run_ff, one_run_in;
   logic [WORD_W-1:0] shift_word_ff, shift_word_in;
   logic [BYTE_W-1:0] window_count_ff, window_count_in;
   logic [WORD_W-1:0] first_word_ff, first_word_in;
   logic [WORD_W-1:0] second_word_ff, second_word_in;
   logic              level_a_ff, level_a_in;
   logic              level_b_ff, level_b_in;

   logic [WORD_W-1:0] min_wide;

   assign min_wide = {{(WORD_W-BYTE_W){1'b0}}, cfg.min_votes};

   // Next state and result for one sample tick, in the order the decisions apply.
   always_comb begin
      armed_in        = armed_ff;
      tick_count_in   = tick_count_ff;
      low_votes_in    = low_votes_ff;
      high_votes_in   = high_votes_ff;
      zero_run_in     = zero_run_ff;
      one_run_in      = one_run_ff;
      shift_word_in   = shift_word_ff;
      window_count_in = window_count_ff;
      first_word_in   = first_word_ff;
      second_word_in  = second_word_ff;
      level_a_in      = level_a_ff;
      level_b_in      = level_b_ff;

      res             = '0;
      res.stage_event = EV_NONE;
      res.seg_first   = first_word_ff;
      res.seg_second  = second_word_ff;

      if (!armed_ff) begin
         // A low sample while idle only arms the receiver.
         if (!line_level) begin
            armed_in = 1'b1;
         end
      end else begin
         tick_count_in = tick_count_ff + 8'd1;
         if (!line_level) begin
            low_votes_in = low_votes_ff + 16'd1;
         end else begin
            high_votes_in = high_votes_ff + 16'd1;
         end

         if (tick_count_in == cfg.window_ticks) begin
            tick_count_in = '0;

            // Majority decision for a one bit.
            if (low_votes_in >= min_wide && low_votes_in > high_votes_in) begin
               low_votes_in  = '0;
               high_votes_in = '0;
               zero_run_in   = '0;
               if (one_run_in != RUN_SAT) begin
                  one_run_in = one_run_in + 3'd1;
               end
               shift_word_in = {shift_word_in[WORD_W-2:0], 1'b1};
               res.bit_valid = 1'b1;
               res.bit_value = 1'b1;
            end

            // Majority decision for a zero bit; never true after a one bit.
            if (high_votes_in >= min_wide && high_votes_in > low_votes_in) begin
               low_votes_in  = '0;
               high_votes_in = '0;
               one_run_in    = '0;
               if (zero_run_in != RUN_SAT) begin
                  zero_run_in = zero_run_in + 3'd1;
               end
               shift_word_in = {shift_word_in[WORD_W-2:0], 1'b0};
               res.bit_valid = 1'b1;
               res.bit_value = 1'b0;
            end

            window_count_in = window_count_ff + 8'd1;

            // Too many equal bits in a row drops the frame.
            if (zero_run_in > MAX_RUN || one_run_in > MAX_RUN) begin
               shift_word_in   = '0;
               first_word_in   = '0;
               second_word_in  = '0;
               window_count_in = '0;
               zero_run_in     = '0;
               one_run_in      = '0;
               armed_in        = 1'b0;
               res.stage_event = EV_ABORT;
            end

            // Segment captures.
            if (window_count_in == cfg.first_split) begin
               first_word_in   = shift_word_in;
               shift_word_in   = '0;
               res.stage_event = EV_FIRST;
            end
            if (window_count_in == cfg.second_split) begin
               second_word_in  = shift_word_in;
               shift_word_in   = '0;
               res.stage_event = EV_SECOND;
            end
            res.seg_first  = first_word_in;
            res.seg_second = second_word_in;

            // Frame completion and code match.
            if (window_count_in == cfg.frame_end) begin
               res.seg_final = shift_word_in;
               if (shift_word_in == cfg.code_a || shift_word_in == ALT_A) begin
                  res.hit_a  = 1'b1;
                  level_a_in = ~level_a_ff;
               end
               if (shift_word_in == cfg.code_b || shift_word_in == ALT_B) begin
                  res.hit_b  = 1'b1;
                  level_b_in = ~level_b_ff;
               end
               shift_word_in   = '0;
               first_word_in   = '0;
               second_word_in  = '0;
               window_count_in = '0;
               armed_in        = 1'b0;
               res.stage_event = EV_DONE;
            end
         end
      end

      res.armed_now = armed_in;
      res.out_a     = level_a_in;
      res.out_b     = level_b_in;
   end

   // Receiver state, advanced once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         tick_count_ff   <= '0;
         low_votes_ff    <= '0;
         high_votes_ff   <= '0;
         zero_run_ff     <= '0;
         one_run_ff      <= '0;
         shift_word_ff   <= '0;
         window_count_ff <= '0;
         first_word_ff   <= '0;
         second_word_ff  <= '0;
         level_a_ff      <= 1'b0;
         level_b_ff      <= 1'b0;
      end else if (fire) begin
         armed_ff        <= armed_in;
         tick_count_ff   <= tick_count_in;
         low_votes_ff    <= low_votes_in;
         high_votes_ff   <= high_votes_in;
         zero_run_ff     <= zero_run_in;
         one_run_ff      <= one_run_in;
         shift_word_ff   <= shift_word_in;
         window_count_ff <= window_count_in;
         first_word_ff   <= first_word_in;
         second_word_ff  <= second_word_in;
         level_a_ff      <= level_a_in;
         level_b_ff      <= level_b_in;
      end
   end

   // Only one of the two run counters can be counting at a time.
   assert property (@(posedge clock) disable iff (reset)
      !(zero_run_ff != '0 && one_run_ff != '0))
      else $error("zero and one run counters both nonzero");

   // A high sample while idle leaves the receiver idle.
   assert property (@(posedge clock) disable iff (reset)
      fire && !armed_ff && line_level |=> !armed_ff)
      else $error("receiver armed on a high sample");

   // While idle, the tick counter does not move.
   assert property (@(posedge clock) disable iff (reset)
      fire && !armed_ff |=> $stable(tick_count_ff))
      else $error("tick counter moved while idle");

   // Frame completion and abort always leave the receiver idle.
   assert property (@(posedge clock) disable iff (reset)
      fire && (res.stage_event == EV_DONE || res.stage_event == EV_ABORT)
      |=> !armed_ff)
      else $error("receiver still armed after frame end or abort");

   // No bit is decided on a tick that finds the receiver idle.
   assert property (@(posedge clock) disable iff (reset)
      fire && !armed_ff |-> !res.bit_valid && res.stage_event == EV_NONE)
      else $error("bit or event reported while idle");

endmodule

>>> design/majority_vote_code_receiver_top.sv
// Top level of the majority-vote code receiver: input register, core, result register.
// Depends on mvcr_pkg, mvcr_csr and mvcr_core.
//
// Usage:
//   req_ channel: one sample tick of the active-low code line per item
//   (req_line_level). rsp_ channel: exactly one result item per tick, in order.
//   csr_ channel: register writes by index (0 window_ticks .. 6 code_b);
//   csr_ready is always high, so a write completes whenever csr_valid is high.
//   Write registers only while no tick is in flight.
// Path: a tick accepted into the input register is worked on by the combinational core,
//   and the result register loads the core's result when the tick advances, which
//   raises rsp_valid.
// Throughput: one tick per cycle; the core's state update is the only loop, so every
//   stage advances each cycle when the result is taken.
// Reset: the configuration, core and valid registers return to their reset values (the
//   data registers are not reset), the receiver is idle and both channels are empty.
// Stall: when rsp_stall holds a result, the input stage keeps its tick and
//   req_stall rises while that stage is full; nothing is dropped.

module majority_vote_code_receiver_top import mvcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Input ticks.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_line_level,
   // Result items.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_armed_now,
   output logic               rsp_bit_valid,
   output logic               rsp_bit_value,
   output logic [EVENT_W-1:0] rsp_stage_event,
   output logic [WORD_W-1:0]  rsp_seg_first,
   output logic [WORD_W-1:0]  rsp_seg_second,
   output logic [WORD_W-1:0]  rsp_seg_final,
   output logic               rsp_hit_a,
   output logic               rsp_hit_b,
   output logic               rsp_out_a,
   output logic               rsp_out_b,
   // Configuration writes.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type core_res;
   result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic in_level_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   // Configuration registers.
   assign csr_ready = 1'b1;

   mvcr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // The held tick moves into the core when the result register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_line_level;
      end
   end

   // Receiver core.
   mvcr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (advance),
      .line_level (in_level_ff),
      .res        (core_res)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_armed_now   = rsp_ff.armed_now;
   assign rsp_bit_valid   = rsp_ff.bit_valid;
   assign rsp_bit_value   = rsp_ff.bit_value;
   assign rsp_stage_event = rsp_ff.stage_event;
   assign rsp_seg_first   = rsp_ff.seg_first;
   assign rsp_seg_second  = rsp_ff.seg_second;
   assign rsp_seg_final   = rsp_ff.seg_final;
   assign rsp_hit_a       = rsp_ff.hit_a;
   assign rsp_hit_b       = rsp_ff.hit_b;
   assign rsp_out_a       = rsp_ff.out_a;
   assign rsp_out_b       = rsp_ff.out_b;

endmodule
